// ===== rtl/lobm_pkg.sv =====
// ----------------------------------------------------------------------------
// lobm_pkg: shared types and codes of the limit order book matcher
// Action and status codes, result kinds, side codes, the fill-and-kill kind and the trade limit.
// ----------------------------------------------------------------------------
package lobm_pkg;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_CANCEL = 2'd1,
		ACT_MODIFY = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_DONE     = 3'd0,
		ST_DUP_ID   = 3'd1,
		ST_NO_CROSS = 3'd2,
		ST_UNKNOWN  = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	localparam logic KIND_TRADE  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;
	localparam logic SIDE_BUY    = 1'b0;
	localparam logic SIDE_SELL   = 1'b1;
	localparam logic OK_FAK      = 1'b1;
	localparam int   TRADE_LIMIT = 63;

endpackage

// ===== rtl/limit_order_book_matcher_top.sv =====
// ----------------------------------------------------------------------------
// limit_order_book_matcher_top: price-time priority limit order book
// An add runs an id scan, a best-price scan for the fill-and-kill check,
// an insert, then a best-price scan per trade and a last one; a cancel or
// a word refused for its id needs only the id scan. One word is worked at
// a time: in_stall stays high until the machine is back in idle, after the
// status word is registered. Each scan reads the order memory one word per
// cycle. Reset clears the slot valid bits and the arrival counter at once.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_top
	import lobm_pkg::*;
#(
	parameter int ORDER_CAPACITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [31:0] order_id,
	input  logic        side,
	input  logic [23:0] price,
	input  logic [15:0] quantity,
	input  logic        order_kind,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        item_kind,
	output logic [31:0] bid_order_id,
	output logic [31:0] ask_order_id,
	output logic [23:0] trade_price,
	output logic [15:0] trade_quantity,
	output logic [2:0]  status,
	output logic        last
);

	localparam int AW = $clog2(ORDER_CAPACITY);
	localparam int CW = $clog2(ORDER_CAPACITY + 1);

	// One memory word holds all fields of one resting order.
	typedef struct packed {
		logic [31:0] id;
		logic        sd;
		logic [23:0] pr;
		logic [15:0] rem;
		logic        knd;
		logic [31:0] arr;
	} slot_t;

	typedef enum logic [3:0] {
		S_IDLE, S_FIND, S_FAKSCAN, S_FAKCHK, S_INSERT,
		S_BEST, S_MATCH, S_WRB, S_WRA, S_EMIT, S_STATUS, S_WAIT
	} state_t;

	slot_t mem [ORDER_CAPACITY];
	slot_t rd_q;
	logic  mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	slot_t mem_wdata;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rd_q <= mem[mem_raddr];
	end

	state_t state_q;
	logic [ORDER_CAPACITY-1:0] valid_q;
	logic [31:0] arrival_q;
	logic [1:0]  act_q;
	logic [31:0] id_q;
	logic        side_q, kind_q;
	logic [23:0] price_q;
	logic [15:0] qty_q;
	// Scan address issued this cycle; the word arrives next cycle.
	logic [CW-1:0] scan_q;
	logic [AW-1:0] cur_q;
	logic          cur_v_q;
	logic          found_q;
	logic [AW-1:0] idx_q, slot_q;
	// Best bid and best ask tracking during a scan.
	logic          bb_v_q, ba_v_q;
	logic [AW-1:0] bb_i_q, ba_i_q;
	slot_t         bb_q, ba_q;
	logic [5:0]    ntr_q;
	logic [15:0]   fill_q;
	logic [2:0]    st_q;

	// Output register.
	logic        ov_q, okind_q, olast_q;
	logic [31:0] obid_q, oask_q;
	logic [23:0] opr_q;
	logic [15:0] oqty_q;
	logic [2:0]  ost_q;

	assign in_stall       = state_q != S_IDLE;
	assign out_valid      = ov_q;
	assign item_kind      = okind_q;
	assign bid_order_id   = obid_q;
	assign ask_order_id   = oask_q;
	assign trade_price    = opr_q;
	assign trade_quantity = oqty_q;
	assign status         = ost_q;
	assign last           = olast_q;

	// The scanning states stream one address per cycle; a result word is
	// loaded when the output register is empty or being taken.
	logic scanning, out_go;
	assign scanning = state_q == S_FIND || state_q == S_FAKSCAN || state_q == S_BEST;
	assign out_go   = (state_q == S_EMIT || state_q == S_STATUS) && (!ov_q || !out_stall);

	// Priority compare of a scanned word against the current best.
	logic rd_live, bid_better, ask_better;
	always_comb begin
		rd_live = cur_v_q && valid_q[cur_q];
		if (rd_q.pr != bb_q.pr)
			bid_better = rd_q.pr > bb_q.pr;
		else
			bid_better = (arrival_q - rd_q.arr) > (arrival_q - bb_q.arr);
		if (rd_q.pr != ba_q.pr)
			ask_better = rd_q.pr < ba_q.pr;
		else
			ask_better = (arrival_q - rd_q.arr) > (arrival_q - ba_q.arr);
	end

	logic scan_end;
	assign scan_end = !cur_v_q && (scan_q == CW'(ORDER_CAPACITY));

	always_comb begin
		mem_raddr = scan_q[AW-1:0];
		if (scan_q >= CW'(ORDER_CAPACITY))
			mem_raddr = '0;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot_q;
		mem_wdata = bb_q;
		case (state_q)
			S_INSERT: begin
				mem_we    = 1'b1;
				mem_waddr = slot_q;
				mem_wdata = '{id: id_q, sd: side_q, pr: price_q, rem: qty_q,
					knd: kind_q, arr: arrival_q};
			end
			S_WRB: begin
				mem_we    = 1'b1;
				mem_waddr = bb_i_q;
				mem_wdata = bb_q;
				mem_wdata.rem = bb_q.rem - fill_q;
			end
			S_WRA: begin
				mem_we    = 1'b1;
				mem_waddr = ba_i_q;
				mem_wdata = ba_q;
				mem_wdata.rem = ba_q.rem - fill_q;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			arrival_q <= '0;
			ov_q      <= 1'b0;
			scan_q    <= '0;
			cur_v_q   <= 1'b0;
		end else begin
			if (out_go)
				ov_q <= 1'b1;
			else if (ov_q && !out_stall)
				ov_q <= 1'b0;
			// Scan address stream: one word per cycle.
			cur_v_q <= scanning && (scan_q < CW'(ORDER_CAPACITY));
			if (scan_q < CW'(ORDER_CAPACITY)) begin
				cur_q <= scan_q[AW-1:0];
				if (scanning)
					scan_q <= scan_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q   <= action;
						id_q    <= order_id;
						side_q  <= side;
						price_q <= price;
						qty_q   <= quantity;
						kind_q  <= order_kind;
						found_q <= 1'b0;
						ntr_q   <= '0;
						scan_q  <= '0;
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					if (rd_live && rd_q.id == id_q) begin
						found_q <= 1'b1;
						idx_q   <= cur_q;
						if (act_q == ACT_MODIFY)
							kind_q <= rd_q.knd;
					end
					if (scan_end) begin
						case (act_q)
							ACT_ADD: begin
								if (found_q) begin
									st_q    <= ST_DUP_ID;
									state_q <= S_STATUS;
								end else begin
									scan_q  <= '0;
									bb_v_q  <= 1'b0;
									ba_v_q  <= 1'b0;
									state_q <= S_FAKSCAN;
								end
							end
							ACT_CANCEL: begin
								state_q <= S_STATUS;
								if (found_q) begin
									valid_q[idx_q] <= 1'b0;
									st_q <= ST_DONE;
								end else begin
									st_q <= ST_UNKNOWN;
								end
							end
							ACT_MODIFY: begin
								if (found_q) begin
									valid_q[idx_q] <= 1'b0;
									scan_q  <= '0;
									bb_v_q  <= 1'b0;
									ba_v_q  <= 1'b0;
									state_q <= S_FAKSCAN;
								end else begin
									st_q    <= ST_UNKNOWN;
									state_q <= S_STATUS;
								end
							end
							default: begin
								st_q    <= ST_DONE;
								state_q <= S_STATUS;
							end
						endcase
					end
				end
				S_FAKSCAN: begin
					// Best of both sides, used for the fill-and-kill check.
					if (rd_live) begin
						if (rd_q.sd == SIDE_BUY && (!bb_v_q || bid_better)) begin
							bb_v_q <= 1'b1; bb_q <= rd_q; bb_i_q <= cur_q;
						end
						if (rd_q.sd == SIDE_SELL && (!ba_v_q || ask_better)) begin
							ba_v_q <= 1'b1; ba_q <= rd_q; ba_i_q <= cur_q;
						end
					end
					if (scan_end)
						state_q <= S_FAKCHK;
				end
				S_FAKCHK: begin
					if (kind_q == OK_FAK &&
						((side_q == SIDE_BUY && (!ba_v_q || price_q < ba_q.pr)) ||
						 (side_q == SIDE_SELL && (!bb_v_q || price_q > bb_q.pr)))) begin
						st_q    <= ST_NO_CROSS;
						state_q <= S_STATUS;
					end else if (&valid_q) begin
						st_q    <= ST_FULL;
						state_q <= S_STATUS;
					end else begin
						for (int i = ORDER_CAPACITY - 1; i >= 0; i--)
							if (!valid_q[i])
								slot_q <= AW'(i);
						state_q <= S_INSERT;
					end
				end
				S_INSERT: begin
					valid_q[slot_q] <= 1'b1;
					arrival_q <= arrival_q + 1'b1;
					scan_q  <= '0;
					bb_v_q  <= 1'b0;
					ba_v_q  <= 1'b0;
					st_q    <= ST_DONE;
					state_q <= S_BEST;
				end
				S_BEST: begin
					if (rd_live) begin
						if (rd_q.sd == SIDE_BUY && (!bb_v_q || bid_better)) begin
							bb_v_q <= 1'b1; bb_q <= rd_q; bb_i_q <= cur_q;
						end
						if (rd_q.sd == SIDE_SELL && (!ba_v_q || ask_better)) begin
							ba_v_q <= 1'b1; ba_q <= rd_q; ba_i_q <= cur_q;
						end
					end
					if (scan_end) begin
						if (bb_v_q && ba_v_q && bb_q.pr >= ba_q.pr &&
							ntr_q != 6'(TRADE_LIMIT)) begin
							fill_q  <= (bb_q.rem < ba_q.rem) ? bb_q.rem : ba_q.rem;
							state_q <= S_MATCH;
						end else begin
							if (kind_q == OK_FAK)
								valid_q[slot_q] <= 1'b0;
							state_q <= S_STATUS;
						end
					end
				end
				S_MATCH: state_q <= S_WRB;
				S_WRB: begin
					if (bb_q.rem == fill_q)
						valid_q[bb_i_q] <= 1'b0;
					state_q <= S_WRA;
				end
				S_WRA: begin
					if (ba_q.rem == fill_q)
						valid_q[ba_i_q] <= 1'b0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_go) begin
						okind_q <= KIND_TRADE;
						obid_q  <= bb_q.id;
						oask_q  <= ba_q.id;
						opr_q   <= bb_q.pr;
						oqty_q  <= fill_q;
						ost_q   <= ST_DONE;
						olast_q <= 1'b0;
						ntr_q   <= ntr_q + 1'b1;
						scan_q  <= '0;
						bb_v_q  <= 1'b0;
						ba_v_q  <= 1'b0;
						state_q <= S_BEST;
					end
				end
				S_STATUS: begin
					if (out_go) begin
						okind_q <= KIND_STATUS;
						obid_q  <= '0;
						oask_q  <= '0;
						opr_q   <= '0;
						oqty_q  <= '0;
						ost_q   <= st_q;
						olast_q <= 1'b1;
						state_q <= S_WAIT;
					end
				end
				S_WAIT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
